// ----- hdl/pn_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pn_pkg
// Shared types and constants of the path normalizer: item kinds, parser
// state, memory write beat and sequencer states.
// ----------------------------------------------------------------------------
package pn_pkg;

  localparam int PATH_BYTES = 256;
  localparam int ADDR_W     = $clog2(PATH_BYTES);

  localparam logic [ADDR_W-1:0] MAX_LEN = ADDR_W'(PATH_BYTES - 1);

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_RD_RES = 2'd1,
    KIND_ADOPT  = 2'd2,
    KIND_RD_DIR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    FEED_NONE  = 2'd0,
    FEED_TAKE  = 2'd1,
    FEED_CLOSE = 2'd2
  } feed_op_t;

  typedef struct packed {
    logic [ADDR_W-1:0] rl;
    logic [ADDR_W-1:0] combined;
    logic [ADDR_W-1:0] part_len;
    logic [15:0]       part_fc;
    logic              stopped;
    logic              tail_slash;
  } parse_t;

  localparam parse_t PARSE_INIT = '{
    rl:         ADDR_W'(1),
    combined:   '0,
    part_len:   '0,
    part_fc:    '0,
    stopped:    1'b0,
    tail_slash: 1'b1
  };

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIR_RD,
    ST_DIR_FEED,
    ST_SEP_FEED,
    ST_CHAR_FEED,
    ST_FINAL,
    ST_POP_RD,
    ST_POP_CMP,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_READ_OUT
  } state_t;

endpackage
`default_nettype wire

// ----- hdl/pn_feed.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pn_feed
// One parser step: takes a byte of combined text or closes the open
// component; returns next parser state, result store write and pop request.
// ----------------------------------------------------------------------------
module pn_feed
  import pn_pkg::*;
(
  input  feed_op_t   op,
  input  logic [7:0] fb,
  input  parse_t     cur,
  output parse_t     nxt,
  output mem_wr_t    wr,
  output logic       pop_go
);

  logic              need_sep;
  logic              do_close;
  logic              is_dot;
  logic              is_dotdot;
  logic [ADDR_W:0]   base;
  logic [ADDR_W:0]   pos;

  always_comb begin
    nxt      = cur;
    wr       = '0;
    pop_go   = 1'b0;
    do_close = 1'b0;

    need_sep  = (cur.rl > ADDR_W'(1)) && !cur.tail_slash;
    base      = {1'b0, cur.rl} + (ADDR_W + 1)'(need_sep);
    pos       = base + {1'b0, cur.part_len};
    is_dot    = (cur.part_len == ADDR_W'(1)) && (cur.part_fc[7:0] == CH_DOT);
    is_dotdot = (cur.part_len == ADDR_W'(2)) && (cur.part_fc == {CH_DOT, CH_DOT});

    case (op)
      FEED_TAKE: begin
        if (cur.combined < MAX_LEN) begin
          nxt.combined = cur.combined + ADDR_W'(1);
          if (fb == CH_SLASH) begin
            do_close = 1'b1;
          end else if (!cur.stopped) begin
            // stage component bytes behind the committed result
            if (pos < {1'b0, MAX_LEN}) begin
              wr = '{en: 1'b1, addr: pos[ADDR_W-1:0], data: fb};
            end
            if (cur.part_len == '0) begin
              nxt.part_fc[7:0] = fb;
            end else if (cur.part_len == ADDR_W'(1)) begin
              nxt.part_fc[15:8] = fb;
            end
            if (cur.part_len < MAX_LEN) begin
              nxt.part_len = cur.part_len + ADDR_W'(1);
            end
          end
        end
      end
      FEED_CLOSE: do_close = 1'b1;
      default: ;
    endcase

    if (do_close) begin
      nxt.part_len = '0;
      nxt.part_fc  = '0;
      if (cur.part_len != '0 && !cur.stopped && !is_dot) begin
        if (is_dotdot) begin
          if (cur.rl > ADDR_W'(1)) begin
            pop_go = 1'b1;
            if (cur.tail_slash) begin
              nxt.rl = cur.rl - ADDR_W'(1);
            end
          end
        end else if (need_sep && cur.rl >= MAX_LEN) begin
          nxt.stopped = 1'b1;
        end else begin
          if (need_sep) begin
            wr = '{en: 1'b1, addr: cur.rl, data: CH_SLASH};
          end
          nxt.rl         = (pos > {1'b0, MAX_LEN}) ? MAX_LEN : pos[ADDR_W-1:0];
          // the last kept byte stays a slash when no component byte fits
          nxt.tail_slash = (base >= {1'b0, MAX_LEN});
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/path_normalizer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Reads (kinds 1 and 3): the memory byte is registered, then the result beat is
// registered once the output is free; input ready stays low until then. Path
// bytes each take a parser step, the final byte also a closing step; a ".." pop
// walks back in the result memory to the last slash; a relative path's first
// byte first feeds the directory; adopt copies the result to the directory.
// Reset: synchronous; then '/' goes into directory byte 0 and input ready rises.
// ----------------------------------------------------------------------------
// path_normalizer_top
// Streaming path normalizer against a stored current directory, built
// around a result memory and a directory memory walked by a sequencer.
// ----------------------------------------------------------------------------
module path_normalizer_top
  import pn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [7:0] path_char, [15:8] read_index
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
  input  wire logic        s_axis_tlast,   // final_char
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [7:0] path_length, [15:8] byte_value
);

  logic [7:0] res_mem [PATH_BYTES];
  logic [7:0] dir_mem [PATH_BYTES];

  state_t            state, state_next;
  state_t            ret_state, ret_state_next;
  parse_t            ps, ps_next;
  logic              path_started, path_started_next;
  logic [ADDR_W-1:0] dir_length, dir_length_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [7:0]        cur_char, cur_char_next;
  logic              cur_final, cur_final_next;
  logic [ADDR_W-1:0] rd_len, rd_len_next;
  logic              rd_hit, rd_hit_next;
  logic              rd_dir, rd_dir_next;
  logic              out_valid, out_valid_next;
  logic [7:0]        out_len, out_len_next;
  logic [7:0]        out_byte, out_byte_next;

  mem_wr_t           res_wr;
  logic              res_re;
  logic [ADDR_W-1:0] res_ra;
  logic [7:0]        res_q;
  mem_wr_t           dir_wr;
  logic              dir_re;
  logic [ADDR_W-1:0] dir_ra;
  logic [7:0]        dir_q;

  feed_op_t          feed_op;
  logic [7:0]        feed_byte;
  state_t            feed_cont;
  parse_t            ps_feed;
  mem_wr_t           feed_wr;
  logic              pop_go;

  kind_t             in_kind;
  logic [7:0]        in_char;
  logic [ADDR_W-1:0] in_idx;

  assign in_kind = kind_t'(s_axis_tuser);
  assign in_char = s_axis_tdata[7:0];
  assign in_idx  = ADDR_W'(s_axis_tdata[15:8]);

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_byte, out_len};

  pn_feed u_feed (
    .op     (feed_op),
    .fb     (feed_byte),
    .cur    (ps),
    .nxt    (ps_feed),
    .wr     (feed_wr),
    .pop_go (pop_go)
  );

  always_ff @(posedge clk) begin
    if (res_wr.en) begin
      res_mem[res_wr.addr] <= res_wr.data;
    end
    if (res_re) begin
      res_q <= res_mem[res_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (dir_wr.en) begin
      dir_mem[dir_wr.addr] <= dir_wr.data;
    end
    if (dir_re) begin
      dir_q <= dir_mem[dir_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      ps           <= PARSE_INIT;
      path_started <= 1'b0;
      dir_length   <= ADDR_W'(1);
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      ps           <= ps_next;
      path_started <= path_started_next;
      dir_length   <= dir_length_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ret_state <= ret_state_next;
    idx       <= idx_next;
    cur_char  <= cur_char_next;
    cur_final <= cur_final_next;
    rd_len    <= rd_len_next;
    rd_hit    <= rd_hit_next;
    rd_dir    <= rd_dir_next;
    out_len   <= out_len_next;
    out_byte  <= out_byte_next;
  end

  always_comb begin
    state_next        = state;
    ret_state_next    = ret_state;
    ps_next           = ps;
    path_started_next = path_started;
    dir_length_next   = dir_length;
    idx_next          = idx;
    cur_char_next     = cur_char;
    cur_final_next    = cur_final;
    rd_len_next       = rd_len;
    rd_hit_next       = rd_hit;
    rd_dir_next       = rd_dir;
    out_valid_next    = out_valid && !m_axis_tready;
    out_len_next      = out_len;
    out_byte_next     = out_byte;
    res_wr            = '0;
    res_re            = 1'b0;
    res_ra            = '0;
    dir_wr            = '0;
    dir_re            = 1'b0;
    dir_ra            = '0;
    feed_op           = FEED_NONE;
    feed_byte         = '0;
    feed_cont         = ST_IDLE;

    unique case (state)
      ST_INIT: begin
        dir_wr     = '{en: 1'b1, addr: '0, data: CH_SLASH};
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          unique case (in_kind)
            KIND_CHAR: begin
              cur_char_next  = in_char;
              cur_final_next = s_axis_tlast;
              if (!path_started) begin
                path_started_next = 1'b1;
                ps_next           = PARSE_INIT;
                res_wr            = '{en: 1'b1, addr: '0, data: CH_SLASH};
                if (in_char != CH_SLASH) begin
                  idx_next   = '0;
                  state_next = ST_DIR_RD;
                end else begin
                  state_next = ST_CHAR_FEED;
                end
              end else begin
                state_next = ST_CHAR_FEED;
              end
            end
            KIND_RD_RES: begin
              res_re      = 1'b1;
              res_ra      = in_idx;
              rd_len_next = ps.rl;
              rd_hit_next = in_idx < ps.rl;
              rd_dir_next = 1'b0;
              state_next  = ST_READ_OUT;
            end
            KIND_RD_DIR: begin
              dir_re      = 1'b1;
              dir_ra      = in_idx;
              rd_len_next = dir_length;
              rd_hit_next = in_idx < dir_length;
              rd_dir_next = 1'b1;
              state_next  = ST_READ_OUT;
            end
            KIND_ADOPT: begin
              idx_next   = '0;
              state_next = ST_COPY_RD;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_DIR_RD: begin
        if (idx < dir_length) begin
          dir_re     = 1'b1;
          dir_ra     = idx;
          state_next = ST_DIR_FEED;
        end else begin
          state_next = ST_SEP_FEED;
        end
      end
      ST_DIR_FEED: begin
        feed_op   = FEED_TAKE;
        feed_byte = dir_q;
        feed_cont = ST_DIR_RD;
        idx_next  = idx + ADDR_W'(1);
      end
      ST_SEP_FEED: begin
        if (dir_length > ADDR_W'(1)) begin
          feed_op   = FEED_TAKE;
          feed_byte = CH_SLASH;
          feed_cont = ST_CHAR_FEED;
        end else begin
          state_next = ST_CHAR_FEED;
        end
      end
      ST_CHAR_FEED: begin
        if (cur_char != 8'h00) begin
          feed_op   = FEED_TAKE;
          feed_byte = cur_char;
          feed_cont = cur_final ? ST_FINAL : ST_IDLE;
        end else begin
          state_next = cur_final ? ST_FINAL : ST_IDLE;
        end
      end
      ST_FINAL: begin
        feed_op           = FEED_CLOSE;
        feed_cont         = ST_IDLE;
        path_started_next = 1'b0;
      end
      ST_POP_RD: begin
        if (ps.rl > ADDR_W'(1)) begin
          res_re     = 1'b1;
          res_ra     = ps.rl - ADDR_W'(1);
          state_next = ST_POP_CMP;
        end else begin
          ps_next.tail_slash = 1'b1;
          state_next         = ret_state;
        end
      end
      ST_POP_CMP: begin
        if (res_q == CH_SLASH) begin
          ps_next.tail_slash = 1'b1;
          state_next         = ret_state;
        end else begin
          ps_next.rl = ps.rl - ADDR_W'(1);
          state_next = ST_POP_RD;
        end
      end
      ST_COPY_RD: begin
        if (idx < ps.rl) begin
          res_re     = 1'b1;
          res_ra     = idx;
          state_next = ST_COPY_WR;
        end else begin
          dir_length_next = ps.rl;
          state_next      = ST_IDLE;
        end
      end
      ST_COPY_WR: begin
        dir_wr     = '{en: 1'b1, addr: idx, data: res_q};
        idx_next   = idx + ADDR_W'(1);
        state_next = ST_COPY_RD;
      end
      ST_READ_OUT: begin
        if (!out_valid || m_axis_tready) begin
          out_valid_next = 1'b1;
          out_len_next   = 8'(rd_len);
          out_byte_next  = rd_hit ? (rd_dir ? dir_q : res_q) : 8'h00;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // apply one parser step; a ".." detours through the pop walk
    if (feed_op != FEED_NONE) begin
      ps_next        = ps_feed;
      res_wr         = feed_wr;
      ret_state_next = feed_cont;
      state_next     = pop_go ? ST_POP_RD : feed_cont;
    end
  end

endmodule
`default_nettype wire
